// ===== design/kbs_pkg.sv =====
// Shared types and constants for the biphase keyboard serializer.
// No dependencies; every other design file imports this package.
package kbs_pkg;

  // Operation codes carried in the func field of an input beat
  localparam logic [1:0] FUNC_TICK  = 2'd0;
  localparam logic [1:0] FUNC_KEY   = 2'd1;
  localparam logic [1:0] FUNC_READ  = 2'd2;
  localparam logic [1:0] FUNC_WRITE = 2'd3;

  localparam int          KBS_FIFO_DEPTH   = 16;
  localparam logic [15:0] BIT_PERIOD_RESET = 16'd263;
  localparam logic [5:0]  FRAME_HALF_BITS  = 6'd42;
  localparam logic [7:0]  READ_ALL_ONES    = 8'hFF;

  // Bit positions inside the stored control nibble
  localparam int CTRL_ENABLE = 3;
  localparam int CTRL_IRTEST = 2;
  localparam int CTRL_CLK1   = 1;
  localparam int CTRL_HRQ    = 0;

  typedef struct packed {
    logic [1:0] func;
    logic [7:0] key_code;
    logic [7:0] write_data;
  } kbs_in_t;

  typedef struct packed {
    logic       data_line;
    logic       nmi_latch_out;
    logic       nmi_request;
    logic [7:0] read_data;
    logic       key_dropped;
    logic       clk1_select;
    logic       hrq_disable;
    logic       ir_test;
  } kbs_out_t;

  typedef struct packed {
    logic empty;
    logic full;
  } kbs_fifo_stat_t;

  typedef struct packed {
    logic pop;        // take the head scan code into a new frame
    logic line_nxt;   // data line level after this beat
    logic latch_set;  // a half-bit of 1 went out
  } kbs_tx_stat_t;

endpackage

// ===== design/kbs_fifo.sv =====
// Scan code queue: memory array plus read/write pointers with wrap phase.
// Depends on kbs_pkg for the status struct.
module kbs_fifo #(
  parameter int FIFO_DEPTH = kbs_pkg::KBS_FIFO_DEPTH
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    push,
  input  logic [7:0]              push_data,
  input  logic                    pop,
  output kbs_pkg::kbs_fifo_stat_t stat,
  output logic [7:0]              rd_data
);
  import kbs_pkg::*;

  localparam int AW = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam logic [AW-1:0] LAST_ADDR = AW'(FIFO_DEPTH - 1);

  logic [7:0]    mem [FIFO_DEPTH];
  logic [AW-1:0] wr_addr_r, rd_addr_r;
  logic          wr_phase_r, rd_phase_r;
  logic [7:0]    rd_data_r;

  assign stat.empty = (wr_addr_r == rd_addr_r) && (wr_phase_r == rd_phase_r);
  assign stat.full  = (wr_addr_r == rd_addr_r) && (wr_phase_r != rd_phase_r);
  assign rd_data    = rd_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_addr_r  <= '0;
      rd_addr_r  <= '0;
      wr_phase_r <= 1'b0;
      rd_phase_r <= 1'b0;
    end else begin
      if (push) begin
        if (wr_addr_r == LAST_ADDR) begin
          wr_addr_r  <= '0;
          wr_phase_r <= ~wr_phase_r;
        end else begin
          wr_addr_r <= wr_addr_r + AW'(1);
        end
      end
      if (pop) begin
        if (rd_addr_r == LAST_ADDR) begin
          rd_addr_r  <= '0;
          rd_phase_r <= ~rd_phase_r;
        end else begin
          rd_addr_r <= rd_addr_r + AW'(1);
        end
      end
    end
  end

  // Storage and registered read; no reset on payload
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_addr_r] <= push_data;
    end
    if (pop) begin
      rd_data_r <= mem[rd_addr_r];
    end
  end

endmodule

// ===== design/kbs_tx.sv =====
// Frame sender: wait counter, half-bit position and data line level.
// Depends on kbs_pkg for frame constants and the status struct.
module kbs_tx (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  tick,
  input  logic                  fifo_empty,
  input  logic [7:0]            frame_key,
  input  logic [15:0]           bit_period,
  output kbs_pkg::kbs_tx_stat_t stat
);
  import kbs_pkg::*;

  logic [15:0] wait_r, wait_nxt;
  logic [5:0]  pos_r, pos_nxt;
  logic        line_r, line_nxt;
  logic [5:0]  half_idx;
  logic [4:0]  cell_idx;
  logic [2:0]  bit_sel;
  logic        cell_bit;
  logic        half_val;
  logic        pop;
  logic        send;

  // Half-bit value: start 1, data LSB first, odd parity, stop cells all 0
  always_comb begin
    half_idx = pos_r - 6'd1;
    cell_idx = half_idx[5:1];
    bit_sel  = 3'(cell_idx - 5'd1);
    cell_bit = 1'b0;
    if (cell_idx == 5'd0) begin
      cell_bit = 1'b1;
    end else if (cell_idx <= 5'd8) begin
      cell_bit = frame_key[bit_sel];
    end else if (cell_idx == 5'd9) begin
      cell_bit = ~^frame_key;
    end
    if (cell_idx <= 5'd9) begin
      half_val = half_idx[0] ? ~cell_bit : cell_bit;
    end else begin
      half_val = 1'b0;
    end
  end

  always_comb begin
    wait_nxt = wait_r;
    pos_nxt  = pos_r;
    line_nxt = line_r;
    pop      = 1'b0;
    send     = 1'b0;
    if (tick) begin
      if (wait_r != 16'd0) begin
        wait_nxt = wait_r - 16'd1;
      end else if (pos_r != 6'd0) begin
        send     = 1'b1;
        line_nxt = half_val;
        pos_nxt  = (pos_r >= FRAME_HALF_BITS) ? 6'd0 : pos_r + 6'd1;
        wait_nxt = bit_period;
      end else if (!fifo_empty) begin
        pop     = 1'b1;
        pos_nxt = 6'd1;
      end
    end
  end

  assign stat.pop       = pop;
  assign stat.line_nxt  = line_nxt;
  assign stat.latch_set = send & half_val;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wait_r <= '0;
      pos_r  <= '0;
      line_r <= 1'b0;
    end else begin
      wait_r <= wait_nxt;
      pos_r  <= pos_nxt;
      line_r <= line_nxt;
    end
  end

endmodule

// ===== design/biphase_keyboard_serializer.sv =====
// Biphase keyboard serializer, top level: handshake, latch, control bits, result register.
// Depends on kbs_pkg, kbs_fifo and kbs_tx.
// An accepted input beat's result beat is registered in the output register, in the cycle after it.
// Throughput: one beat per cycle; in_ready drops only while a result waits and out_ready is low.
// Reset (rst_n, synchronous, active low) empties the queue, idles the frame sender,
// clears the latch and control bits and loads the bit period with 263. No clearing pass.
module biphase_keyboard_serializer #(
  parameter int FIFO_DEPTH = kbs_pkg::KBS_FIFO_DEPTH
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  kbs_pkg::kbs_in_t in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output kbs_pkg::kbs_out_t out_data,
  input  logic             cfg_wr_en,
  input  logic [15:0]      cfg_wr_data
);
  import kbs_pkg::*;

  logic           accept;
  logic           is_tick, is_key, is_read, is_write;
  logic           push;
  logic           dropped;
  kbs_fifo_stat_t fifo_stat;
  logic [7:0]     frame_key;
  kbs_tx_stat_t   tx_stat;

  logic [15:0] bit_period_r;
  logic        latch_r, latch_nxt;
  logic [3:0]  ctrl_r, ctrl_nxt;
  logic        prev_nmi_r;
  logic        nmi_now;
  logic        out_valid_r;
  kbs_out_t    out_data_r, out_data_nxt;

  // Accept whenever the result register is free or being drained this cycle
  assign in_ready  = !out_valid_r || out_ready;
  assign accept    = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign is_tick  = accept && (in_data.func == FUNC_TICK);
  assign is_key   = accept && (in_data.func == FUNC_KEY);
  assign is_read  = accept && (in_data.func == FUNC_READ);
  assign is_write = accept && (in_data.func == FUNC_WRITE);

  // Drop the scan code when the queue is full; nothing else moves
  assign push    = is_key && !fifo_stat.full;
  assign dropped = is_key && fifo_stat.full;

  kbs_fifo #(
    .FIFO_DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (in_data.key_code),
    .pop       (tx_stat.pop),
    .stat      (fifo_stat),
    .rd_data   (frame_key)
  );

  // The key read on a pop lands in the cycle after it; the first two half-bits
  // (start cell) do not look at it, so it is always in place in time.
  kbs_tx u_tx (
    .clk        (clk),
    .rst_n      (rst_n),
    .tick       (is_tick),
    .fifo_empty (fifo_stat.empty),
    .frame_key  (frame_key),
    .bit_period (bit_period_r),
    .stat       (tx_stat)
  );

  always_comb begin
    latch_nxt = latch_r;
    if (is_read) begin
      latch_nxt = 1'b0;
    end else if (tx_stat.latch_set) begin
      latch_nxt = 1'b1;
    end
    ctrl_nxt = is_write ? in_data.write_data[7:4] : ctrl_r;
    // NMI request: rising edge of latch AND enable, seen after this beat
    nmi_now = latch_nxt & ctrl_nxt[CTRL_ENABLE];

    out_data_nxt.data_line     = tx_stat.line_nxt;
    out_data_nxt.nmi_latch_out = latch_nxt;
    out_data_nxt.nmi_request   = nmi_now & ~prev_nmi_r;
    out_data_nxt.read_data     = is_read ? READ_ALL_ONES : 8'd0;
    out_data_nxt.key_dropped   = dropped;
    out_data_nxt.clk1_select   = ctrl_nxt[CTRL_CLK1];
    out_data_nxt.hrq_disable   = ctrl_nxt[CTRL_HRQ];
    out_data_nxt.ir_test       = ctrl_nxt[CTRL_IRTEST];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bit_period_r <= BIT_PERIOD_RESET;
      latch_r      <= 1'b0;
      ctrl_r       <= '0;
      prev_nmi_r   <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        bit_period_r <= cfg_wr_data;
      end
      if (accept) begin
        latch_r     <= latch_nxt;
        ctrl_r      <= ctrl_nxt;
        prev_nmi_r  <= nmi_now;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Result payload: hold until the next accepted beat
  always_ff @(posedge clk) begin
    if (accept) begin
      out_data_r <= out_data_nxt;
    end
  end

endmodule
